// ===== design/frp_pkg.sv =====
// Shared constants, codes and payload types of the frame rate pacer.
package frp_pkg;

  localparam int TICKS_PER_SECOND = 1000000;
  localparam int MAX_RATE         = 240;
  localparam int TIME_BITS        = 48;

  localparam int RATE_BITS     = 8;
  localparam int FIELD_BITS    = 20;
  localparam int CNT_BITS      = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 8;
  // interval never exceeds the tick rate itself (rate of at least one)
  localparam int IVL_BITS      = $clog2(TICKS_PER_SECOND + 1);
  localparam int DIV_BITS      = (IVL_BITS > RATE_BITS) ? IVL_BITS : RATE_BITS;
  localparam int DIV_STEP_BITS = $clog2(TIME_BITS + 1);
  localparam logic [FIELD_BITS-1:0] FIELD_MAX = {FIELD_BITS{1'b1}};

  typedef enum logic [2:0] {
    MODE_DISABLED    = 3'd0,
    MODE_PROFILING   = 3'd1,
    MODE_MINIMIZED   = 3'd2,
    MODE_BACKGROUND  = 3'd3,
    MODE_PLAY        = 3'd4,
    MODE_INTERACTION = 3'd5,
    MODE_REALTIME    = 3'd6,
    MODE_IDLE        = 3'd7
  } mode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_PACING_ENABLED   = 3'd0,
    REG_PLAY_RATE        = 3'd1,
    REG_INTERACTION_RATE = 3'd2,
    REG_REALTIME_RATE    = 3'd3,
    REG_IDLE_RATE        = 3'd4,
    REG_BACKGROUND_RATE  = 3'd5,
    REG_MINIMIZED_RATE   = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic                 pacing_enabled;
    logic [RATE_BITS-1:0] play_rate;
    logic [RATE_BITS-1:0] interaction_rate;
    logic [RATE_BITS-1:0] realtime_rate;
    logic [RATE_BITS-1:0] idle_rate;
    logic [RATE_BITS-1:0] background_rate;
    logic [RATE_BITS-1:0] minimized_rate;
  } frp_cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ticks;
    logic                 profiling_uncapped;
    logic                 is_minimized;
    logic                 in_foreground;
    logic                 play_active;
    logic                 interaction_active;
    logic                 viewport_continuous;
  } frp_in_t;

  typedef struct packed {
    mode_t                 pace_mode;
    logic [RATE_BITS-1:0]  target_rate;
    logic [FIELD_BITS-1:0] interval_ticks;
    logic [FIELD_BITS-1:0] wait_ticks;
    logic [CNT_BITS-1:0]   late_count;
    logic [CNT_BITS-1:0]   frame_count;
  } frp_out_t;

endpackage

// ===== design/frp_cfg.sv =====
// Configuration registers with rate clamping and pacing-state clear strobe.
module frp_cfg import frp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data,
  output frp_cfg_t                 cfg,
  output logic                     cfg_clear
);

  logic [RATE_BITS-1:0] rate_clamped;

  always_comb begin
    if (cfg_data == '0) begin
      rate_clamped = RATE_BITS'(1);
    end else if (int'(cfg_data) > MAX_RATE) begin
      rate_clamped = RATE_BITS'(MAX_RATE);
    end else begin
      rate_clamped = cfg_data[RATE_BITS-1:0];
    end
  end

  // any known index also wipes the pacing state
  assign cfg_clear = cfg_we && (cfg_index <= REG_MINIMIZED_RATE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pacing_enabled   <= 1'b1;
      cfg.play_rate        <= RATE_BITS'(60);
      cfg.interaction_rate <= RATE_BITS'(60);
      cfg.realtime_rate    <= RATE_BITS'(60);
      cfg.idle_rate        <= RATE_BITS'(30);
      cfg.background_rate  <= RATE_BITS'(10);
      cfg.minimized_rate   <= RATE_BITS'(5);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PACING_ENABLED:   cfg.pacing_enabled   <= cfg_data[0];
        REG_PLAY_RATE:        cfg.play_rate        <= rate_clamped;
        REG_INTERACTION_RATE: cfg.interaction_rate <= rate_clamped;
        REG_REALTIME_RATE:    cfg.realtime_rate    <= rate_clamped;
        REG_IDLE_RATE:        cfg.idle_rate        <= rate_clamped;
        REG_BACKGROUND_RATE:  cfg.background_rate  <= rate_clamped;
        REG_MINIMIZED_RATE:   cfg.minimized_rate   <= rate_clamped;
        default: ;
      endcase
    end
  end

endmodule

// ===== design/frp_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
module frp_div import frp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [TIME_BITS-1:0] dividend,
  input  logic [DIV_BITS-1:0]  divisor,
  output logic                 done,
  output logic [TIME_BITS-1:0] quotient,
  output logic [DIV_BITS-1:0]  remainder
);

  logic                     running;
  logic [DIV_STEP_BITS-1:0] steps;
  logic [DIV_BITS-1:0]      dsr;
  logic [DIV_BITS:0]        trial;
  logic [DIV_BITS:0]        diff;

  assign trial = {remainder, quotient[TIME_BITS-1]};
  assign diff  = trial - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      steps   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        steps   <= DIV_STEP_BITS'(TIME_BITS);
      end else if (running) begin
        steps <= steps - 1'b1;
        if (steps == DIV_STEP_BITS'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
      dsr       <= divisor;
    end else if (running) begin
      if (trial >= {1'b0, dsr}) begin
        remainder <= diff[DIV_BITS-1:0];
        quotient  <= {quotient[TIME_BITS-2:0], 1'b1};
      end else begin
        remainder <= trial[DIV_BITS-1:0];
        quotient  <= {quotient[TIME_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== design/frame_rate_pacer.sv =====
// Frame rate pacer: one result per frame item. A steady capped frame runs the
// shared bit-serial divider twice (interval from the rate, then the deadline
// remainder); a first frame or a change of mode or rate needs one division,
// and an uncapped frame none. frame_ready is high only while no item is in
// work, so the next item can be taken in the cycle in which a result appears
// at the earliest; a finished result may wait in the output register while
// the next item enters.
module frame_rate_pacer import frp_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     frame_valid,
  output logic                     frame_ready,
  input  frp_in_t                  frame,
  output logic                     result_valid,
  input  logic                     result_ready,
  output frp_out_t                 result,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIVI = 6'b000100,
    S_STEP = 6'b001000,
    S_DIVR = 6'b010000,
    S_DONE = 6'b100000
  } state_t;

  state_t                state;
  frp_cfg_t              cfg;
  logic                  cfg_clear;
  frp_in_t               item;
  mode_t                 mode;
  logic [RATE_BITS-1:0]  rate;
  logic [IVL_BITS-1:0]   interval;
  logic [TIME_BITS-1:0]  now_eff;
  logic [FIELD_BITS-1:0] wait_ticks;
  logic                  deadline_valid;
  logic [TIME_BITS-1:0]  next_deadline;
  mode_t                 last_mode;
  logic [RATE_BITS-1:0]  last_rate;
  logic [CNT_BITS-1:0]   late_counter;
  logic [CNT_BITS-1:0]   frame_counter;

  mode_t                 sel_mode;
  logic [RATE_BITS-1:0]  sel_rate;
  logic [TIME_BITS-1:0]  ivl_wide;
  logic                  early;
  logic [TIME_BITS-1:0]  now_eff_c;
  logic [TIME_BITS-1:0]  early_gap;
  logic                  changed;

  logic                  div_start;
  logic [TIME_BITS-1:0]  div_dividend;
  logic [DIV_BITS-1:0]   div_divisor;
  logic                  div_done;
  logic [TIME_BITS-1:0]  div_quotient;
  logic [DIV_BITS-1:0]   div_remainder;

  frp_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg),
    .cfg_clear (cfg_clear)
  );

  frp_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

  assign frame_ready = (state == S_IDLE);

  // fixed priority mode pick
  always_comb begin
    if (!cfg.pacing_enabled) begin
      sel_mode = MODE_DISABLED;
      sel_rate = '0;
    end else if (item.profiling_uncapped) begin
      sel_mode = MODE_PROFILING;
      sel_rate = '0;
    end else if (item.is_minimized) begin
      sel_mode = MODE_MINIMIZED;
      sel_rate = cfg.minimized_rate;
    end else if (!item.in_foreground) begin
      sel_mode = MODE_BACKGROUND;
      sel_rate = cfg.background_rate;
    end else if (item.play_active) begin
      sel_mode = MODE_PLAY;
      sel_rate = cfg.play_rate;
    end else if (item.interaction_active) begin
      sel_mode = MODE_INTERACTION;
      sel_rate = cfg.interaction_rate;
    end else if (item.viewport_continuous) begin
      sel_mode = MODE_REALTIME;
      sel_rate = cfg.realtime_rate;
    end else begin
      sel_mode = MODE_IDLE;
      sel_rate = cfg.idle_rate;
    end
  end

  assign ivl_wide  = TIME_BITS'(interval);
  assign early     = item.now_ticks < next_deadline;
  assign now_eff_c = early ? next_deadline : item.now_ticks;
  assign early_gap = next_deadline - item.now_ticks;
  assign changed   = !deadline_valid || (last_mode != mode) || (last_rate != rate);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = TIME_BITS'(TICKS_PER_SECOND);
    div_divisor  = DIV_BITS'(sel_rate);
    case (state)
      S_PREP: div_start = (sel_rate != '0);
      S_STEP: begin
        div_start    = !changed;
        // now_eff_c never lies before the deadline here
        div_dividend = now_eff_c - next_deadline;
        div_divisor  = DIV_BITS'(interval);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      result_valid   <= 1'b0;
      deadline_valid <= 1'b0;
      next_deadline  <= '0;
      last_mode      <= MODE_DISABLED;
      last_rate      <= '0;
      late_counter   <= '0;
      frame_counter  <= '0;
    end else begin
      // in S_DONE the case below sets the valid flag itself
      if (result_valid && result_ready && (state != S_DONE)) begin
        result_valid <= 1'b0;
      end
      if (cfg_clear) begin
        deadline_valid <= 1'b0;
        next_deadline  <= '0;
        last_mode      <= MODE_DISABLED;
        last_rate      <= '0;
        late_counter   <= '0;
        frame_counter  <= '0;
      end
      case (state)
        S_IDLE: begin
          if (frame_valid) begin
            state <= S_PREP;
          end
        end
        S_PREP: begin
          if (sel_rate == '0) begin
            deadline_valid <= 1'b0;
            state          <= S_DONE;
          end else begin
            state <= S_DIVI;
          end
        end
        S_DIVI: begin
          if (div_done) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (changed) begin
            next_deadline  <= item.now_ticks + ivl_wide;
            deadline_valid <= 1'b1;
            state          <= S_DONE;
          end else begin
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_done) begin
            if (now_eff > next_deadline + ivl_wide) begin
              late_counter <= late_counter + 1'b1;
            end
            // whole intervals past now: now - (now - deadline) mod interval + interval
            next_deadline <= now_eff - TIME_BITS'(div_remainder) + ivl_wide;
            state         <= S_DONE;
          end
        end
        S_DONE: begin
          if (!result_valid || result_ready) begin
            result_valid  <= 1'b1;
            last_mode     <= mode;
            last_rate     <= rate;
            frame_counter <= frame_counter + 1'b1;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // item payload and per-item working values
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (frame_valid) begin
          item <= frame;
        end
      end
      S_PREP: begin
        mode       <= sel_mode;
        rate       <= sel_rate;
        interval   <= '0;
        wait_ticks <= '0;
      end
      S_DIVI: begin
        if (div_done) begin
          if (div_quotient == '0) begin
            interval <= IVL_BITS'(1);
          end else begin
            interval <= div_quotient[IVL_BITS-1:0];
          end
        end
      end
      S_STEP: begin
        now_eff <= now_eff_c;
        if (!changed && early) begin
          if (early_gap > TIME_BITS'(FIELD_MAX)) begin
            wait_ticks <= FIELD_MAX;
          end else begin
            wait_ticks <= early_gap[FIELD_BITS-1:0];
          end
        end
      end
      S_DONE: begin
        if (!result_valid || result_ready) begin
          result.pace_mode   <= mode;
          result.target_rate <= rate;
          if (ivl_wide > TIME_BITS'(FIELD_MAX)) begin
            result.interval_ticks <= FIELD_MAX;
          end else begin
            result.interval_ticks <= ivl_wide[FIELD_BITS-1:0];
          end
          result.wait_ticks  <= wait_ticks;
          result.late_count  <= late_counter;
          result.frame_count <= frame_counter + 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

// ===== design/frp_check.sv =====
// Port-level checks of the frame rate pacer, bound to the top level.
module frp_check import frp_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     frame_valid,
  input logic                     frame_ready,
  input logic                     result_valid,
  input logic                     result_ready,
  input frp_out_t                 result
);

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid after reset");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    frame_valid && frame_ready |=> !frame_ready)
    else $error("second item taken while one is in work");

  a_uncapped_no_wait: assert property (@(posedge clk) disable iff (rst)
    result_valid && (result.pace_mode == MODE_DISABLED ||
                     result.pace_mode == MODE_PROFILING)
    |-> result.target_rate == '0 && result.interval_ticks == '0 &&
        result.wait_ticks == '0)
    else $error("uncapped item reports rate, interval or wait");

  a_capped_interval: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.target_rate != '0 |-> result.interval_ticks != '0)
    else $error("capped item with zero interval");

endmodule

bind frame_rate_pacer frp_check u_frp_check (.*);
